// ===== rtl/ttlc_pkg.sv =====
// Package: shared constants and types for the TTL cache table.
package ttlc_pkg;
  localparam int ENTRIES_DEF   = 64;
  localparam int TIME_BITS_DEF = 48;
  localparam int KEY_W   = 64;
  localparam int VAL_W   = 64;
  localparam int CNT_W   = 32;
  localparam int OCC_W   = 7;
  localparam int TTL_W   = 20;
  localparam int MAXE_W  = 7;
  localparam int IDX_W   = 2;
  localparam int NOWIN_W = 48;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_INVAL  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  localparam logic [IDX_W-1:0] REG_ENABLE = 2'd0;
  localparam logic [IDX_W-1:0] REG_MAXE   = 2'd1;
  localparam logic [IDX_W-1:0] REG_TTL    = 2'd2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [9:0] MS_PER_S = 10'd1000;
endpackage

// ===== rtl/ttlc_if.sv =====
// Interfaces: command, result and configuration channels.
interface ttlc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [63:0] key;
  logic [63:0] value_in;
  logic [47:0] now_ms;
  modport source (output valid, command, key, value_in, now_ms, input ready);
  modport sink   (input valid, command, key, value_in, now_ms, output ready);
endinterface

interface ttlc_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [63:0] value_out;
  logic [6:0]  occupancy;
  logic [31:0] hit_total;
  logic [31:0] miss_total;
  modport source (output valid, hit, value_out, occupancy, hit_total, miss_total,
                  input ready);
  modport sink   (input valid, hit, value_out, occupancy, hit_total, miss_total,
                  output ready);
endinterface

interface ttlc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/ttlc_core.sv =====
// Scan engine: slot memory and the per-command sequencer.
module ttlc_core #(
  parameter int ENTRIES   = ttlc_pkg::ENTRIES_DEF,
  parameter int TIME_BITS = ttlc_pkg::TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [1:0]  cmd,
  input  logic [63:0] key,
  input  logic [63:0] val,
  input  logic [47:0] now_in,
  input  logic        en,
  input  logic [6:0]  max_e,
  input  logic [19:0] ttl,
  output logic        busy,
  output logic        done,
  output logic        hit,
  output logic [63:0] vout,
  output logic [6:0]  occ,
  output logic [31:0] hits,
  output logic [31:0] misses
);
  localparam int AW   = $clog2(ENTRIES);
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int CMPW = (CW > 7) ? CW : 7;
  // slot word: {valid, key, value, created}
  localparam int SLW  = 1 + 64 + 64 + TIME_BITS;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_SCAN, S_LAST, S_EVICT, S_WRITE, S_DONE
  } st_t;

  st_t st_r;
  logic [SLW-1:0] mem [ENTRIES];
  logic [SLW-1:0] rd_r;
  logic [AW-1:0] addr_r, raddr_r;
  logic          rd_ok_r;
  logic [1:0]    cmd_r;
  logic [63:0]   key_r, val_r;
  logic [TIME_BITS-1:0] now_r;
  logic [TIME_BITS-1:0] lim_r;
  logic [CW-1:0] live_r;
  logic [31:0]   hits_r, misses_r;
  // scan results
  logic          kf_r, fr_f_r, old_f_r;
  logic [AW-1:0] ks_r, fr_r, old_r;
  logic [TIME_BITS-1:0] kage_r, oage_r;
  logic [63:0]   kval_r;
  logic [AW-1:0] wslot_r;
  logic          keep_r;

  logic                 rd_vld;
  logic [63:0]          rd_key;
  logic [TIME_BITS-1:0] rd_created, age;
  logic [AW-1:0]        wslot, dslot, waddr;
  logic                 evk, keep_key, drop, ins, we;
  logic [SLW-1:0]       wdata;

  assign rd_vld     = rd_r[SLW-1];
  assign rd_key     = rd_r[SLW-2 -: 64];
  assign rd_created = rd_r[TIME_BITS-1:0];
  assign age        = now_r - rd_created;

  // store eviction: oldest when count at or above limit; then key slot, else lowest free
  // (the evicted slot counts as free, and as lowest if no earlier free slot)
  always_comb begin
    logic [AW-1:0] fs;
    logic ff;
    evk = en && (CMPW'(live_r) >= CMPW'(max_e)) && old_f_r;
    ff = fr_f_r;
    fs = fr_r;
    if (evk && (!ff || old_r < fs)) begin
      ff = 1'b1;
      fs = old_r;
    end
    keep_key = kf_r && !(evk && old_r == ks_r);
    if (keep_key) wslot = ks_r;
    else if (ff) wslot = fs;
    else wslot = old_r;
  end

  // slot emptied in the evict step
  always_comb begin
    drop  = 1'b0;
    dslot = ks_r;
    case (cmd_r)
      ttlc_pkg::CMD_LOOKUP: drop = en && kf_r && (kage_r > lim_r);
      ttlc_pkg::CMD_STORE: begin
        drop  = en && (evk || (!kf_r && !fr_f_r && old_f_r));
        dslot = old_r;
      end
      ttlc_pkg::CMD_INVAL: drop = kf_r;
      default: ;
    endcase
  end

  assign ins = (cmd_r == ttlc_pkg::CMD_STORE) && en && (kf_r || fr_f_r || old_f_r);

  always_comb begin
    we    = 1'b0;
    waddr = wslot_r;
    wdata = {1'b1, key_r, val_r, now_r};
    case (st_r)
      S_INIT: begin
        we    = 1'b1;
        waddr = addr_r;
        wdata = '0;
      end
      S_EVICT: begin
        we    = drop;
        waddr = dslot;
        wdata = '0;
      end
      S_WRITE: we = ins;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[addr_r];
  end

  assign busy = st_r != S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_INIT;
      addr_r <= '0;
      cmd_r <= ttlc_pkg::CMD_LOOKUP;
      live_r <= '0;
      hits_r <= '0;
      misses_r <= '0;
      done <= 1'b0;
      hit <= 1'b0;
      vout <= '0;
    end else begin
      done <= st_r == S_DONE;
      case (st_r)
        // clearing pass: after reset and for a clear request
        S_INIT: begin
          if (addr_r == AW'(ENTRIES - 1)) begin
            addr_r <= '0;
            st_r <= (cmd_r == ttlc_pkg::CMD_CLEAR) ? S_DONE : S_IDLE;
          end else addr_r <= addr_r + 1'b1;
        end
        S_IDLE: if (start) begin
          cmd_r <= cmd; key_r <= key; val_r <= val;
          now_r <= TIME_BITS'(now_in);
          lim_r <= TIME_BITS'(30'(ttl) * 30'(ttlc_pkg::MS_PER_S));
          addr_r <= '0; rd_ok_r <= 1'b0;
          kf_r <= 1'b0; fr_f_r <= 1'b0; old_f_r <= 1'b0;
          hit <= 1'b0; vout <= '0;
          if (cmd == ttlc_pkg::CMD_CLEAR) begin
            live_r <= '0; hits_r <= '0; misses_r <= '0;
            st_r <= S_INIT;
          end else st_r <= S_SCAN;
        end
        S_SCAN, S_LAST: begin
          if (rd_ok_r && rd_vld) begin
            if (rd_key == key_r && !kf_r) begin
              kf_r <= 1'b1; ks_r <= raddr_r; kage_r <= age;
              kval_r <= rd_r[TIME_BITS +: 64];
            end
            if (!old_f_r || age > oage_r) begin
              old_f_r <= 1'b1; old_r <= raddr_r; oage_r <= age;
            end
          end else if (rd_ok_r && !fr_f_r) begin
            fr_f_r <= 1'b1; fr_r <= raddr_r;
          end
          raddr_r <= addr_r;
          rd_ok_r <= st_r == S_SCAN;
          if (st_r == S_LAST) st_r <= S_EVICT;
          else if (addr_r == AW'(ENTRIES - 1)) st_r <= S_LAST;
          else addr_r <= addr_r + 1'b1;
        end
        S_EVICT: begin
          // target slot fixed before the count moves
          wslot_r <= wslot;
          keep_r <= keep_key;
          if (drop && live_r != '0) live_r <= live_r - 1'b1;
          if (cmd_r == ttlc_pkg::CMD_LOOKUP && en) begin
            if (kf_r && !drop) begin
              hit <= 1'b1; vout <= kval_r;
              if (hits_r != ttlc_pkg::CNT_MAX) hits_r <= hits_r + 1'b1;
            end else if (misses_r != ttlc_pkg::CNT_MAX) misses_r <= misses_r + 1'b1;
          end
          st_r <= S_WRITE;
        end
        S_WRITE: begin
          if (ins && !keep_r) live_r <= live_r + 1'b1;
          st_r <= S_DONE;
        end
        S_DONE: st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign occ = 7'(live_r);
  assign hits = hits_r;
  assign misses = misses_r;

  a_live: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= CW'(ENTRIES)) else $error("live count above table size");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> $past(st_r) == S_DONE) else $error("done outside finish state");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("start not taken");
  a_wr: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (st_r == S_INIT || st_r == S_EVICT || st_r == S_WRITE))
    else $error("slot write outside write states");
endmodule

// ===== rtl/ttl_cache_table_core.sv =====
// Top level: TTL cache table with oldest-entry eviction.
// Channels: in (command, key, value_in, now_ms), out (hit, value_out,
// occupancy, hit_total, miss_total), cfg (index, data write; always ready).
// Each request gives exactly one result. A request is scanned against all
// ENTRIES slots through the slot memory's single read port, one slot a
// cycle. Clear rewrites every slot as empty through the write port. One
// request is in flight at a time: the next request is accepted the cycle
// after the previous result is taken. Reset runs the same clearing pass
// with the input held off, zeroes the counters and loads cache_enable=1,
// max_entries=64, ttl_seconds=3600. A stalled receiver holds the result in
// the output register and blocks further requests.
module ttl_cache_table_core #(
  parameter int ENTRIES   = ttlc_pkg::ENTRIES_DEF,
  parameter int TIME_BITS = ttlc_pkg::TIME_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  ttlc_in_if.sink    in_ch,
  ttlc_out_if.source out_ch,
  ttlc_cfg_if.sink   cfg_ch
);
  logic en_r;
  logic [6:0] maxe_r;
  logic [19:0] ttl_r;
  logic busy, done, hit;
  logic [63:0] vout;
  logic [6:0] occ;
  logic [31:0] hits, misses;
  logic ov_r, start;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b1; maxe_r <= 7'd64; ttl_r <= 20'd3600;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        ttlc_pkg::REG_ENABLE: en_r <= cfg_ch.data[0];
        ttlc_pkg::REG_MAXE:   maxe_r <= cfg_ch.data[6:0];
        ttlc_pkg::REG_TTL:    ttl_r <= cfg_ch.data[19:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !busy && !ov_r && !done;
  assign start = in_ch.valid && in_ch.ready;

  ttlc_core #(.ENTRIES(ENTRIES), .TIME_BITS(TIME_BITS)) u_core (
    .clk, .rst_n, .start, .cmd(in_ch.command), .key(in_ch.key),
    .val(in_ch.value_in), .now_in(in_ch.now_ms), .en(en_r), .max_e(maxe_r),
    .ttl(ttl_r), .busy, .done, .hit, .vout, .occ, .hits, .misses
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (done) ov_r <= 1'b1;
    else if (out_ch.ready) ov_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (done) begin
      out_ch.hit <= hit; out_ch.value_out <= vout; out_ch.occupancy <= occ;
      out_ch.hit_total <= hits; out_ch.miss_total <= misses;
    end
  end
  assign out_ch.valid = ov_r;
endmodule

// ===== tb/ttlc_checker.sv =====
`timescale 1ns / 1ps
// Checker: tracks cache state from observed requests and compares every result.
module ttlc_checker (
  input  logic clk,
  input  logic rst_n,
  ttlc_in_if.sink   in_mon,
  ttlc_out_if.sink  out_mon,
  ttlc_cfg_if.sink  cfg_mon,
  output int        fail_count,
  output int        pending_count,
  output int        results_seen,
  output int        evictions_seen,
  output int        expiries_seen
);
  localparam int SLOTS = ttlc_pkg::ENTRIES_DEF;
  localparam logic [47:0] AGE_MASK = '1;

  typedef struct packed {
    logic        hit;
    logic [63:0] value_out;
    logic [6:0]  occupancy;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } cache_result_t;

  logic        cs_valid [SLOTS];
  logic [63:0] cs_key   [SLOTS];
  logic [63:0] cs_value [SLOTS];
  logic [47:0] cs_born  [SLOTS];
  logic [6:0]  cs_live;
  logic [31:0] cs_hits, cs_misses;
  logic        cs_enable;
  logic [6:0]  cs_max;
  logic [19:0] cs_ttl;

  cache_result_t expected_results[$];

  function automatic int slot_of(logic [63:0] k);
    for (int i = 0; i < SLOTS; i++)
      if (cs_valid[i] && cs_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int first_free();
    for (int i = 0; i < SLOTS; i++)
      if (!cs_valid[i]) return i;
    return -1;
  endfunction

  function automatic void drop(int i);
    cs_valid[i] = 1'b0;
    if (cs_live > 0) cs_live--;
  endfunction

  function automatic void evict_oldest(logic [47:0] now);
    int best;
    logic [47:0] best_age, age;
    best = -1;
    best_age = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (cs_valid[i]) begin
        age = (now - cs_born[i]) & AGE_MASK;
        if (best < 0 || age > best_age) begin
          best = i;
          best_age = age;
        end
      end
    end
    if (best >= 0) begin
      drop(best);
      evictions_seen++;
    end
  endfunction

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == ttlc_pkg::CNT_MAX) ? v : v + 32'd1;
  endfunction

  function automatic cache_result_t apply_request(ttlc_pkg::cmd_t cmd, logic [63:0] k,
                                                  logic [63:0] v, logic [47:0] now);
    cache_result_t r;
    int s;
    logic [47:0] age;
    r = '0;
    case (cmd)
      ttlc_pkg::CMD_LOOKUP: begin
        if (cs_enable) begin
          s = slot_of(k);
          if (s < 0) cs_misses = bump(cs_misses);
          else begin
            age = now - cs_born[s];
            if ({16'd0, age} > 64'(cs_ttl) * 64'd1000) begin
              drop(s);
              cs_misses = bump(cs_misses);
              expiries_seen++;
            end else begin
              cs_hits = bump(cs_hits);
              r.hit = 1'b1;
              r.value_out = cs_value[s];
            end
          end
        end
      end
      ttlc_pkg::CMD_STORE: begin
        if (cs_enable) begin
          if (cs_live >= cs_max) evict_oldest(now);
          s = slot_of(k);
          if (s < 0) begin
            s = first_free();
            if (s < 0) begin
              evict_oldest(now);
              s = first_free();
            end
            if (s >= 0) begin
              cs_valid[s] = 1'b1;
              cs_live++;
            end
          end
          if (s >= 0) begin
            cs_key[s] = k;
            cs_value[s] = v;
            cs_born[s] = now;
          end
        end
      end
      ttlc_pkg::CMD_INVAL: begin
        s = slot_of(k);
        if (s >= 0) drop(s);
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) cs_valid[i] = 1'b0;
        cs_live = '0;
        cs_hits = '0;
        cs_misses = '0;
      end
    endcase
    r.occupancy = cs_live;
    r.hit_total = cs_hits;
    r.miss_total = cs_misses;
    return r;
  endfunction

  always @(posedge clk) begin
    cache_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) cs_valid[i] = 1'b0;
      cs_live = '0;
      cs_hits = '0;
      cs_misses = '0;
      cs_enable = 1'b1;
      cs_max = 7'd64;
      cs_ttl = 20'd3600;
      expected_results.delete();
      fail_count <= 0;
      results_seen <= 0;
      evictions_seen = 0;
      expiries_seen = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          ttlc_pkg::REG_ENABLE: cs_enable = cfg_mon.data[0];
          ttlc_pkg::REG_MAXE:   cs_max = cfg_mon.data[6:0];
          ttlc_pkg::REG_TTL:    cs_ttl = cfg_mon.data[19:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(apply_request(ttlc_pkg::cmd_t'(in_mon.command),
                                                 in_mon.key, in_mon.value_in,
                                                 in_mon.now_ms));
      if (out_mon.valid && out_mon.ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $error("unexpected result: nothing pending");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (out_mon.hit !== want.hit ||
              out_mon.value_out !== want.value_out ||
              out_mon.occupancy !== want.occupancy ||
              out_mon.hit_total !== want.hit_total ||
              out_mon.miss_total !== want.miss_total)
            fail_count <= fail_count + 1;
          if (out_mon.hit !== want.hit)
            $error("hit: expected %0d actual %0d", want.hit, out_mon.hit);
          if (out_mon.value_out !== want.value_out)
            $error("value_out: expected %h actual %h", want.value_out, out_mon.value_out);
          if (out_mon.occupancy !== want.occupancy)
            $error("occupancy: expected %0d actual %0d", want.occupancy, out_mon.occupancy);
          if (out_mon.hit_total !== want.hit_total)
            $error("hit_total: expected %0d actual %0d", want.hit_total, out_mon.hit_total);
          if (out_mon.miss_total !== want.miss_total)
            $error("miss_total: expected %0d actual %0d", want.miss_total,
                   out_mon.miss_total);
        end
      end
    end
    pending_count = expected_results.size();
  end
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench top: stimulus, configuration phases and verdict for the TTL cache.
module tb;
  localparam int STALL_LIMIT = 5000;

  logic clk, rst_n;
  int   fail_count, pending_count, results_seen, evictions_seen, expiries_seen;
  int   idle_cycles;
  bit   timed_out;

  ttlc_in_if  in_ch();
  ttlc_out_if out_ch();
  ttlc_cfg_if cfg_ch();

  ttl_cache_table_core dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink),
                            .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink));

  ttlc_checker chk (.clk(clk), .rst_n(rst_n), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
                    .cfg_mon(cfg_ch.sink), .fail_count(fail_count),
                    .pending_count(pending_count), .results_seen(results_seen),
                    .evictions_seen(evictions_seen), .expiries_seen(expiries_seen));

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  logic [63:0] key_pool[8];
  logic [47:0] clock_ms;

  // Watchdog: cycles with no request, result or config accepted.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("tb: FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, with stretches of always-ready.
  initial begin
    int hold;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      repeat (hold) begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk iff out_ch.valid);
    end
  end

  task automatic send_request(ttlc_pkg::cmd_t cmd, logic [63:0] k, logic [63:0] v,
                              logic [47:0] now, bit use_gap);
    int gap;
    gap = use_gap ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= cmd;
    in_ch.key      <= k;
    in_ch.value_in <= v;
    in_ch.now_ms   <= now;
    @(posedge clk iff in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk iff cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly keys from a small pool so lookups hit and stores collide.
  task automatic random_phase(int count, logic [47:0] max_step);
    int r;
    logic [63:0] k;
    ttlc_pkg::cmd_t cmd;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      cmd = (r < 45) ? ttlc_pkg::CMD_LOOKUP :
            (r < 85) ? ttlc_pkg::CMD_STORE :
            (r < 97) ? ttlc_pkg::CMD_INVAL : ttlc_pkg::CMD_CLEAR;
      k = ($urandom_range(0, 9) != 0) ? key_pool[$urandom_range(0, 7)]
                                      : {$urandom, $urandom};
      clock_ms = 48'(clock_ms + {$urandom, $urandom} % (max_step + 48'd1));
      send_request(cmd, k, {$urandom, $urandom}, clock_ms, n % 64 < 40);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = ttlc_pkg::CMD_LOOKUP;
    in_ch.key = '0;
    in_ch.value_in = '0;
    in_ch.now_ms = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = ttlc_pkg::REG_ENABLE;
    cfg_ch.data = '0;
    timed_out = 1'b0;
    rst_n = 1'b0;
    for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, every command, expiry at the boundary, wrap, eviction.
    send_request(ttlc_pkg::CMD_LOOKUP, '0, '0, '0, 1'b0);
    send_request(ttlc_pkg::CMD_STORE, '0, '1, '0, 1'b0);
    send_request(ttlc_pkg::CMD_STORE, '1, 64'h5A5A_A5A5_0F0F_F0F0, 48'hFFFF_FFFF_FFF0, 1'b0);
    send_request(ttlc_pkg::CMD_LOOKUP, '0, '0, 48'd3_600_000, 1'b0);
    send_request(ttlc_pkg::CMD_LOOKUP, '0, '0, 48'd3_600_001, 1'b0);
    send_request(ttlc_pkg::CMD_LOOKUP, '1, '0, 48'd100, 1'b0);
    send_request(ttlc_pkg::CMD_STORE, '1, 64'hA5A5_5A5A_F0F0_0F0F, 48'd200, 1'b0);
    send_request(ttlc_pkg::CMD_INVAL, '1, '0, 48'd300, 1'b0);
    send_request(ttlc_pkg::CMD_INVAL, '1, '0, 48'd300, 1'b0);
    send_request(ttlc_pkg::CMD_LOOKUP, '1, '0, 48'd400, 1'b0);
    send_request(ttlc_pkg::CMD_STORE, 64'd7, 64'd70, 48'd500, 1'b0);
    send_request(ttlc_pkg::CMD_CLEAR, '0, '0, 48'd600, 1'b0);
    send_request(ttlc_pkg::CMD_LOOKUP, 64'd7, '0, 48'd700, 1'b0);
    drain();

    write_reg(ttlc_pkg::REG_MAXE, 32'd2);
    write_reg(ttlc_pkg::REG_TTL, 32'd0);
    send_request(ttlc_pkg::CMD_STORE, 64'd1, 64'd11, 48'd10, 1'b0);
    send_request(ttlc_pkg::CMD_STORE, 64'd2, 64'd22, 48'd10, 1'b0);
    send_request(ttlc_pkg::CMD_STORE, 64'd2, 64'd23, 48'd20, 1'b0);
    send_request(ttlc_pkg::CMD_STORE, 64'd1, 64'd12, 48'd20, 1'b0);
    send_request(ttlc_pkg::CMD_STORE, 64'd3, 64'd33, 48'd30, 1'b0);
    send_request(ttlc_pkg::CMD_LOOKUP, 64'd3, '0, 48'd30, 1'b0);
    send_request(ttlc_pkg::CMD_LOOKUP, 64'd3, '0, 48'd31, 1'b0);
    drain();

    write_reg(ttlc_pkg::REG_ENABLE, 32'd0);
    send_request(ttlc_pkg::CMD_STORE, 64'd4, 64'd44, 48'd40, 1'b0);
    send_request(ttlc_pkg::CMD_LOOKUP, 64'd1, '0, 48'd40, 1'b0);
    send_request(ttlc_pkg::CMD_INVAL, 64'd1, '0, 48'd40, 1'b0);
    send_request(ttlc_pkg::CMD_CLEAR, '0, '0, 48'd40, 1'b0);
    drain();

    // Random phases across register settings, extremes included.
    write_reg(ttlc_pkg::REG_ENABLE, 32'd1);
    write_reg(ttlc_pkg::REG_MAXE, 32'd64);
    write_reg(ttlc_pkg::REG_TTL, 32'd1_000_000);
    clock_ms = 48'hFFFF_FF00_0000;
    random_phase(100, 48'hFFFF_FFFF);
    drain();
    write_reg(ttlc_pkg::REG_MAXE, 32'd1);
    write_reg(ttlc_pkg::REG_TTL, 32'd1);
    random_phase(80, 48'd1500);
    drain();
    write_reg(ttlc_pkg::REG_MAXE, 32'd5);
    write_reg(ttlc_pkg::REG_TTL, 32'd2);
    random_phase(100, 48'd800);
    drain();
    write_reg(ttlc_pkg::REG_MAXE, 32'd0);
    write_reg(ttlc_pkg::REG_TTL, 32'hFFFFF);
    random_phase(40, 48'hFFFF_FFFF_FFFF);
    drain();
    write_reg(ttlc_pkg::REG_MAXE, 32'd127);
    write_reg(ttlc_pkg::REG_TTL, 32'd3600);
    for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
    // Fill past 64 slots with fresh keys to hit the full-table eviction.
    for (int n = 0; n < 70; n++) begin
      clock_ms = clock_ms + 48'($urandom_range(0, 3));
      send_request(ttlc_pkg::CMD_STORE, {$urandom, $urandom}, {$urandom, $urandom},
                   clock_ms, 1'b1);
    end
    random_phase(60, 48'd1_000_000);
    drain();
    write_reg(ttlc_pkg::REG_ENABLE, 32'd0);
    random_phase(20, 48'd100);
    drain();
    write_reg(ttlc_pkg::REG_ENABLE, 32'd1);
    write_reg(ttlc_pkg::REG_MAXE, 32'd64);
    random_phase(40, 48'hFFFF);
    drain();

    $display("tb: %0d results checked, %0d evictions, %0d expiries", results_seen,
             evictions_seen, expiries_seen);
    $display("tb: covered all commands, disabled cache, limits 0..127 and ttl extremes");
    if (fail_count == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/ttlc_pkg.sv
rtl/ttlc_if.sv
rtl/ttlc_core.sv
rtl/ttl_cache_table_core.sv
tb/ttlc_checker.sv
tb/tb.sv
